// ===== hdl/ax25_frame_header_checker_unit_defines.svh =====
// assertion macros shared by the ax25 frame header checker modules
// expects clk_i and rst_ni in the scope of every use
`ifndef AX25_FRAME_HEADER_CHECKER_UNIT_DEFINES_SVH
`define AX25_FRAME_HEADER_CHECKER_UNIT_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define AX25HC_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ax25hc: same-cycle check failed");

// antecedent implies consequent in the following cycle
`define AX25HC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ax25hc: next-cycle check failed");

`endif

// ===== hdl/ax25hc_pkg.sv =====
// types, constants and helper functions of the ax25 frame header checker
// used by ax25hc_core, ax25hc_fifo and the top level; depends on nothing
package ax25hc_pkg;

  // frame limits
  localparam int unsigned MAX_PATH    = 15;
  localparam int unsigned MAX_PAYLOAD = 1023;
  localparam int unsigned MIN_FRAME   = 18;

  // result queue depth, a power of two
  localparam int unsigned FIFO_DEPTH = 4;

  // crc-16/x.25, reflected
  localparam logic [15:0] CRC_POLY = 16'h8408;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;

  // header byte values
  localparam logic [7:0] CTRL_UI     = 8'h03;
  localparam logic [7:0] PID_NO_L3   = 8'hF0;
  localparam logic [7:0] CHR_TAB     = 8'h09;
  localparam logic [7:0] CHR_LF      = 8'h0A;
  localparam logic [7:0] CHR_CR      = 8'h0D;
  localparam logic [7:0] PRINT_FIRST = 8'h20;
  localparam logic [7:0] PRINT_LAST  = 8'h7E;

  // number of callsign bytes before the ssid byte
  localparam logic [2:0] CALL_CHARS = 3'd6;

  typedef enum logic [2:0] {
    PH_ADDRESS,
    PH_CONTROL,
    PH_PID,
    PH_PAYLOAD,
    PH_HALT
  } phase_e;

  typedef enum logic [1:0] {
    ROLE_DEST,
    ROLE_SRC,
    ROLE_DIGI
  } role_e;

  typedef enum logic [2:0] {
    ST_OK,
    ST_SHORT,
    ST_BAD_FCS,
    ST_DEST_LAST,
    ST_ADDR_OVERRUN,
    ST_NO_CONTROL,
    ST_NO_PID
  } status_e;

  typedef enum logic {
    KIND_ADDRESS,
    KIND_SUMMARY
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    role_e       role;
    logic [3:0]  path_index;
    logic [41:0] callsign;
    logic [3:0]  ssid;
    status_e     status;
    logic [7:0]  control;
    logic [7:0]  pid;
    logic        is_ui;
    logic        printable;
    logic [9:0]  payload_length;
  } result_t;

  // results produced by one byte step, first in order
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } push_t;

  // one byte into the crc, lsb first
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc;
    for (int i = 0; i < 8; i++) begin
      if (c[0] ^ b[i]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  // printable ascii or cr, lf, tab
  function automatic logic is_printable(input logic [7:0] b);
    return (b == CHR_CR) || (b == CHR_LF) || (b == CHR_TAB) ||
           ((b >= PRINT_FIRST) && (b <= PRINT_LAST));
  endfunction

endpackage

// ===== hdl/ax25_frame_header_checker_unit.sv =====
// ax25 frame header checker: byte input, address records and frame summaries out
// depends on ax25hc_pkg, ax25hc_core and ax25hc_fifo
//
// Input channel: one frame byte per word on data_byte_i, end_of_frame_i high
// on the last byte (the second fcs byte). Frames follow each other directly.
// Output channel: one result per word. result_kind_o low is an address record
// (role, path index, callsign, ssid); high is the frame summary that closes
// the frame (status, control, pid, ui flag, printability, payload length,
// path count).
// Throughput: one byte per cycle while the queue has room. The byte step
// (8-bit crc update and parser step) sits between the input register and a
// four-word result queue; the step on the last byte gives two results when an
// address completes in it, drained one per cycle while out_ready_i is high.
// Reset clears the frame state, the input register's valid flag and the queue.
// When the receiver stalls, the queue fills and in_ready_o drops once fewer
// than two free slots remain and the input register is full; nothing is lost.

module ax25_frame_header_checker_unit #(
  parameter int unsigned MAX_PAYLOAD = ax25hc_pkg::MAX_PAYLOAD
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        end_of_frame_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        result_kind_o,
  output logic [1:0]  address_role_o,
  output logic [3:0]  path_index_o,
  output logic [41:0] callsign_o,
  output logic [3:0]  ssid_o,
  output logic [2:0]  status_o,
  output logic [7:0]  control_o,
  output logic [7:0]  pid_o,
  output logic        is_ui_o,
  output logic        payload_printable_o,
  output logic [9:0]  payload_length_o
);

  logic                in_vld_q, in_vld_d;
  logic [7:0]          byte_q;
  logic                eof_q;
  logic                room;
  logic                step;
  logic                in_take;
  ax25hc_pkg::push_t   push;
  ax25hc_pkg::result_t head;

  // input register handshake
  assign step       = in_vld_q && room;
  assign in_ready_o = !in_vld_q || room;
  assign in_take    = in_valid_i && in_ready_o;

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_take) begin
      in_vld_d = 1'b1;
    end else if (step) begin
      in_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  // input word payload
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      byte_q <= data_byte_i;
      eof_q  <= end_of_frame_i;
    end
  end

  ax25hc_core #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (step),
    .data_byte_i    (byte_q),
    .end_of_frame_i (eof_q),
    .push_o         (push)
  );

  ax25hc_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .head_o      (head)
  );

  // result fields to ports
  assign result_kind_o       = head.kind;
  assign address_role_o      = head.role;
  assign path_index_o        = head.path_index;
  assign callsign_o          = head.callsign;
  assign ssid_o              = head.ssid;
  assign status_o            = head.status;
  assign control_o           = head.control;
  assign pid_o               = head.pid;
  assign is_ui_o             = head.is_ui;
  assign payload_printable_o = head.printable;
  assign payload_length_o    = head.payload_length;

endmodule

// ===== hdl/ax25hc_core.sv =====
// frame state, crc and header parser: one byte step per cycle while step_i is high
// depends on ax25hc_pkg and ax25_frame_header_checker_unit_defines.svh
`include "ax25_frame_header_checker_unit_defines.svh"

module ax25hc_core #(
  parameter int unsigned MAX_PAYLOAD = ax25hc_pkg::MAX_PAYLOAD
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  logic [7:0]         data_byte_i,
  input  logic               end_of_frame_i,
  output ax25hc_pkg::push_t  push_o
);

  localparam int unsigned PW = $clog2(MAX_PAYLOAD + 1);

  logic [7:0]              delay0_q, delay0_d, delay1_q, delay1_d;
  logic [1:0]              fill_q, fill_d;
  logic [15:0]             crc_q, crc_d;
  logic [9:0]              frame_q, frame_d;
  ax25hc_pkg::phase_e      phase_q, phase_d;
  logic [2:0]              addr_idx_q, addr_idx_d;
  logic [41:0]             call_q, call_d;
  ax25hc_pkg::role_e       role_q, role_d;
  logic [3:0]              path_q, path_d;
  logic [7:0]              ctrl_q, ctrl_d;
  logic [7:0]              pid_q, pid_d;
  logic                    print_q, print_d;
  logic [PW-1:0]           pay_q, pay_d;
  ax25hc_pkg::status_e     err_q, err_d;

  logic [7:0]              body;
  logic                    body_vld;
  logic                    rec_vld;
  ax25hc_pkg::result_t     rec;
  ax25hc_pkg::result_t     sum;
  ax25hc_pkg::status_e     status;
  logic [31:0]             pay_ext;

  // byte step: delay line, crc, parser, and the summary at end of frame
  always_comb begin
    delay0_d   = data_byte_i;
    delay1_d   = data_byte_i;
    fill_d     = fill_q;
    crc_d      = crc_q;
    frame_d    = frame_q;
    phase_d    = phase_q;
    addr_idx_d = addr_idx_q;
    call_d     = call_q;
    role_d     = role_q;
    path_d     = path_q;
    ctrl_d     = ctrl_q;
    pid_d      = pid_q;
    print_d    = print_q;
    pay_d      = pay_q;
    err_d      = err_q;
    rec        = '0;
    rec_vld    = 1'b0;
    sum        = '0;
    status     = ax25hc_pkg::ST_OK;
    pay_ext    = '0;
    body       = delay0_q;
    body_vld   = (fill_q == 2'd2);

    // oldest held byte is known body once two newer bytes arrived
    if (body_vld) begin
      crc_d = ax25hc_pkg::crc_byte(crc_q, body);
      unique case (phase_q)
        ax25hc_pkg::PH_ADDRESS: begin
          if (addr_idx_q < ax25hc_pkg::CALL_CHARS) begin
            call_d     = {call_q[34:0], body[7:1]};
            addr_idx_d = addr_idx_q + 3'd1;
          end else begin
            rec_vld         = 1'b1;
            rec.kind        = ax25hc_pkg::KIND_ADDRESS;
            rec.role        = role_q;
            rec.path_index  = (role_q == ax25hc_pkg::ROLE_DIGI) ? path_q : 4'd0;
            rec.callsign    = call_q;
            rec.ssid        = body[4:1];
            if ((role_q == ax25hc_pkg::ROLE_DIGI) && (path_q < 4'(ax25hc_pkg::MAX_PATH))) begin
              path_d = path_q + 4'd1;
            end
            call_d     = '0;
            addr_idx_d = '0;
            if (role_q == ax25hc_pkg::ROLE_DEST) begin
              if (body[0]) begin
                err_d   = ax25hc_pkg::ST_DEST_LAST;
                phase_d = ax25hc_pkg::PH_HALT;
              end
              role_d = ax25hc_pkg::ROLE_SRC;
            end else begin
              if (body[0]) begin
                phase_d = ax25hc_pkg::PH_CONTROL;
              end
              role_d = ax25hc_pkg::ROLE_DIGI;
            end
          end
        end
        ax25hc_pkg::PH_CONTROL: begin
          ctrl_d  = body;
          phase_d = ((body == ax25hc_pkg::CTRL_UI) || !body[0]) ?
                    ax25hc_pkg::PH_PID : ax25hc_pkg::PH_PAYLOAD;
        end
        ax25hc_pkg::PH_PID: begin
          pid_d   = body;
          phase_d = ax25hc_pkg::PH_PAYLOAD;
        end
        ax25hc_pkg::PH_PAYLOAD: begin
          if (pay_q < PW'(MAX_PAYLOAD)) begin
            pay_d = pay_q + PW'(1);
          end
          if (!ax25hc_pkg::is_printable(body)) begin
            print_d = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end

    // delay line and byte count
    delay0_d = delay1_q;
    delay1_d = data_byte_i;
    if (fill_q != 2'd2) begin
      fill_d = fill_q + 2'd1;
    end
    if (frame_q < 10'd1023) begin
      frame_d = frame_q + 10'd1;
    end

    // frame summary, then everything back to its reset value
    if (end_of_frame_i) begin
      if ((frame_d < 10'(ax25hc_pkg::MIN_FRAME)) || (fill_q == 2'd0)) begin
        status = ax25hc_pkg::ST_SHORT;
      end else if (~crc_d != {data_byte_i, delay1_q}) begin
        status = ax25hc_pkg::ST_BAD_FCS;
      end else if (err_d != ax25hc_pkg::ST_OK) begin
        status = err_d;
      end else if (phase_d == ax25hc_pkg::PH_ADDRESS) begin
        status = ax25hc_pkg::ST_ADDR_OVERRUN;
      end else if (phase_d == ax25hc_pkg::PH_CONTROL) begin
        status = ax25hc_pkg::ST_NO_CONTROL;
      end else if (phase_d == ax25hc_pkg::PH_PID) begin
        status = ax25hc_pkg::ST_NO_PID;
      end else begin
        status = ax25hc_pkg::ST_OK;
      end

      pay_ext        = 32'(pay_d);
      sum.kind       = ax25hc_pkg::KIND_SUMMARY;
      sum.path_index = path_d;
      sum.status     = status;
      if (status == ax25hc_pkg::ST_OK) begin
        sum.control        = ctrl_d;
        sum.pid            = pid_d;
        sum.is_ui          = (ctrl_d == ax25hc_pkg::CTRL_UI) && (pid_d == ax25hc_pkg::PID_NO_L3);
        sum.printable      = print_d;
        sum.payload_length = (pay_ext > 32'd1023) ? 10'd1023 : pay_ext[9:0];
      end

      delay0_d   = '0;
      delay1_d   = '0;
      fill_d     = '0;
      crc_d      = ax25hc_pkg::CRC_INIT;
      frame_d    = '0;
      phase_d    = ax25hc_pkg::PH_ADDRESS;
      addr_idx_d = '0;
      call_d     = '0;
      role_d     = ax25hc_pkg::ROLE_DEST;
      path_d     = '0;
      ctrl_d     = '0;
      pid_d      = '0;
      print_d    = 1'b1;
      pay_d      = '0;
      err_d      = ax25hc_pkg::ST_OK;
    end
  end

  // results of this step, address record ahead of the summary
  always_comb begin
    push_o.count  = step_i ? (2'(rec_vld) + 2'(end_of_frame_i)) : 2'd0;
    push_o.first  = rec_vld ? rec : sum;
    push_o.second = sum;
  end

  // frame state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay0_q   <= '0;
      delay1_q   <= '0;
      fill_q     <= '0;
      crc_q      <= ax25hc_pkg::CRC_INIT;
      frame_q    <= '0;
      phase_q    <= ax25hc_pkg::PH_ADDRESS;
      addr_idx_q <= '0;
      call_q     <= '0;
      role_q     <= ax25hc_pkg::ROLE_DEST;
      path_q     <= '0;
      ctrl_q     <= '0;
      pid_q      <= '0;
      print_q    <= 1'b1;
      pay_q      <= '0;
      err_q      <= ax25hc_pkg::ST_OK;
    end else if (step_i) begin
      delay0_q   <= delay0_d;
      delay1_q   <= delay1_d;
      fill_q     <= fill_d;
      crc_q      <= crc_d;
      frame_q    <= frame_d;
      phase_q    <= phase_d;
      addr_idx_q <= addr_idx_d;
      call_q     <= call_d;
      role_q     <= role_d;
      path_q     <= path_d;
      ctrl_q     <= ctrl_d;
      pid_q      <= pid_d;
      print_q    <= print_d;
      pay_q      <= pay_d;
      err_q      <= err_d;
    end
  end

  // a pair of results is always an address record followed by the summary
  `AX25HC_ASSERT_SAME(a_pair_order, push_o.count == 2'd2,
    (push_o.first.kind == ax25hc_pkg::KIND_ADDRESS) &&
    (push_o.second.kind == ax25hc_pkg::KIND_SUMMARY))
  // the parser never runs past the callsign characters
  `AX25HC_ASSERT_SAME(a_addr_idx, 1'b1, addr_idx_q <= ax25hc_pkg::CALL_CHARS)

endmodule

// ===== hdl/ax25hc_fifo.sv =====
// result queue: takes up to two results a cycle, hands out one word a cycle while out_ready_i is high
// depends on ax25hc_pkg and ax25_frame_header_checker_unit_defines.svh
`include "ax25_frame_header_checker_unit_defines.svh"

module ax25hc_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ax25hc_pkg::push_t    push_i,
  output logic                 room_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output ax25hc_pkg::result_t  head_o
);

  localparam int unsigned DEPTH = ax25hc_pkg::FIFO_DEPTH;
  localparam int unsigned PTRW  = $clog2(DEPTH);
  localparam int unsigned CNTW  = $clog2(DEPTH + 1);

  ax25hc_pkg::result_t mem_q [DEPTH];
  logic [PTRW-1:0]     wr_q, wr_d, rd_q, rd_d;
  logic [CNTW-1:0]     cnt_q, cnt_d;
  logic                pop;

  // status and head word
  assign room_o      = (cnt_q <= CNTW'(DEPTH - 2));
  assign out_valid_o = (cnt_q != '0);
  assign pop         = out_valid_o && out_ready_i;
  assign head_o      = mem_q[rd_q];

  // pointer and count update
  always_comb begin
    wr_d  = wr_q + PTRW'(push_i.count);
    rd_d  = pop ? (rd_q + PTRW'(1)) : rd_q;
    cnt_d = cnt_q + CNTW'(push_i.count) - CNTW'(pop);
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      mem_q[wr_q] <= push_i.first;
    end
    if (push_i.count == 2'd2) begin
      mem_q[wr_q + PTRW'(1)] <= push_i.second;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  `AX25HC_ASSERT_SAME(a_no_overflow, push_i.count != 2'd0,
    (cnt_q + CNTW'(push_i.count)) <= CNTW'(DEPTH))
  `AX25HC_ASSERT_SAME(a_count_range, 1'b1, cnt_q <= CNTW'(DEPTH))
  `AX25HC_ASSERT_NEXT(a_pop_only, pop && (push_i.count == 2'd0),
    cnt_q == ($past(cnt_q) - CNTW'(1)))

endmodule
